// ----- design/ptct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse target count tracker package
// Shared types and constants for the tracker: command and status codes, the
// per-channel state entry and the result record.
// ----------------------------------------------------------------------------
package ptct_pkg;

	localparam int unsigned CHANNELS_DEF = 1;
	localparam int unsigned CHANNELS_MAX = 8;
	localparam logic [15:0] WINDOW_RESET = 16'd1024;
	localparam logic [15:0] NOT_ARMED_COMPARE = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_POLL  = 2'd1,
		OP_STOP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_PARAM = 2'd1,
		ST_BUSY  = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] last_count;
		logic [31:0] pulses_done;
		logic [31:0] pulse_target;
		logic        stop_armed;
		logic        active;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] pulse_delta;
		logic        gen_stopped;
		logic        arm_stop;
		logic [15:0] stop_compare;
		logic        counter_clear;
		logic        halt_timers;
	} result_t;

endpackage

// ----- design/ptct_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse target count tracker channels
// Valid/ready channels for commands, results and the configuration write.
// ----------------------------------------------------------------------------
interface ptct_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [2:0]  channel;
	logic [31:0] target_pulses;
	logic [15:0] counter_sample;
	logic        pwm_enabled;

	modport source (output valid, op, channel, target_pulses, counter_sample, pwm_enabled,
		input ready);
	modport sink (input valid, op, channel, target_pulses, counter_sample, pwm_enabled,
		output ready);
endinterface

interface ptct_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] pulse_delta;
	logic        gen_stopped;
	logic        arm_stop;
	logic [15:0] stop_compare;
	logic        counter_clear;
	logic        halt_timers;

	modport source (output valid, status, pulse_delta, gen_stopped, arm_stop, stop_compare,
		counter_clear, halt_timers, input ready);
	modport sink (input valid, status, pulse_delta, gen_stopped, arm_stop, stop_compare,
		counter_clear, halt_timers, output ready);
endinterface

interface ptct_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- design/pulse_target_count_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse target count tracker
// Tracks pulse-train channels against absolute pulse targets.
// ----------------------------------------------------------------------------
// Each request is a start, poll or stop command for one channel and yields
// exactly one result. A request is accepted every cycle while the result
// path flows. The channel state memory is read at the accepting edge, and
// the update is registered into the output when the result path advances.
// Back-to-back requests to the same channel are handled by a write bypass.
// The arm window register may be written at any cycle the block is idle.
module pulse_target_count_tracker_unit
	import ptct_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ptct_cmd_if.sink     cmd,
	ptct_rsp_if.source   rsp,
	ptct_cfg_if.sink     cfg
);

	localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [15:0] window_q;
	logic        vld_s1;
	logic        in_range_s1;
	logic [1:0]  op_s1;
	logic [2:0]  channel_s1;
	logic [31:0] target_s1;
	logic [15:0] sample_s1;
	logic        enabled_s1;
	logic        out_vld_q;
	result_t     out_q;
	logic        advance;
	logic        accept;
	logic        cmd_in_range;
	entry_t      cur;
	entry_t      nxt;
	logic        upd_wr;
	result_t     res;

	assign cfg.ready    = 1'b1;
	assign advance      = !out_vld_q || rsp.ready;
	assign cmd.ready    = !vld_s1 || advance;
	assign accept       = cmd.valid && cmd.ready;
	assign cmd_in_range = (32'(cmd.channel) < CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg.valid && cfg.ready) begin
			window_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				vld_s1 <= cmd.valid;
			end
			if (advance) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= cmd_in_range;
			op_s1       <= cmd.op;
			channel_s1  <= cmd.channel;
			target_s1   <= cmd.target_pulses;
			sample_s1   <= cmd.counter_sample;
			enabled_s1  <= cmd.pwm_enabled;
		end
		if (advance && vld_s1) begin
			out_q <= res;
		end
	end

	ptct_state_mem #(
		.CHANNELS(CHANNELS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && cmd_in_range),
		.rd_addr (cmd.channel[CH_W-1:0]),
		.rd_data (cur),
		.wr_en   (vld_s1 && advance && upd_wr),
		.wr_addr (channel_s1[CH_W-1:0]),
		.wr_data (nxt)
	);

	ptct_update u_update (
		.cur            (cur),
		.in_range       (in_range_s1),
		.op             (op_s1),
		.target_pulses  (target_s1),
		.counter_sample (sample_s1),
		.pwm_enabled    (enabled_s1),
		.window         (window_q),
		.nxt            (nxt),
		.wr             (upd_wr),
		.res            (res)
	);

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_q.status;
	assign rsp.pulse_delta   = out_q.pulse_delta;
	assign rsp.gen_stopped   = out_q.gen_stopped;
	assign rsp.arm_stop      = out_q.arm_stop;
	assign rsp.stop_compare  = out_q.stop_compare;
	assign rsp.counter_clear = out_q.counter_clear;
	assign rsp.halt_timers   = out_q.halt_timers;

endmodule

// ----- design/ptct_state_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse target count tracker state memory
// Per-channel state memory with a registered read, per-entry valid
// bits for the reset value and a bypass of the most recent write.
// ----------------------------------------------------------------------------
module ptct_state_mem
	import ptct_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF,
	localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [CH_W-1:0] rd_addr,
	output entry_t          rd_data,
	input  logic            wr_en,
	input  logic [CH_W-1:0] wr_addr,
	input  entry_t          wr_data
);

	entry_t             mem [CHANNELS];
	logic [CHANNELS-1:0] ent_vld_q;
	entry_t             rd_data_q;
	logic               rd_vld_q;
	logic [CH_W-1:0]    rd_addr_q;
	entry_t             byp_data_q;
	logic [CH_W-1:0]    byp_addr_q;
	logic               byp_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en) begin
			byp_data_q <= wr_data;
			byp_addr_q <= wr_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			byp_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
				byp_vld_q          <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= ent_vld_q[rd_addr];
			end
		end
	end

	always_comb begin
		if (byp_vld_q && (byp_addr_q == rd_addr_q)) begin
			rd_data = byp_data_q;
		end else if (rd_vld_q) begin
			rd_data = rd_data_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// ----- design/ptct_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse target count tracker update
// Applies one command to a channel entry and forms the result record.
// ----------------------------------------------------------------------------
module ptct_update
	import ptct_pkg::*;
(
	input  entry_t      cur,
	input  logic        in_range,
	input  logic [1:0]  op,
	input  logic [31:0] target_pulses,
	input  logic [15:0] counter_sample,
	input  logic        pwm_enabled,
	input  logic [15:0] window,
	output entry_t      nxt,
	output logic        wr,
	output result_t     res
);

	logic [15:0] raw_delta;
	logic [31:0] rem_before;
	logic [15:0] delta;
	logic [31:0] rem_after;
	logic [31:0] window_ext;

	always_comb begin
		raw_delta  = counter_sample - cur.last_count;
		rem_before = (cur.pulses_done >= cur.pulse_target) ? 32'd0
			: (cur.pulse_target - cur.pulses_done);
		delta      = (rem_before < {16'd0, raw_delta}) ? rem_before[15:0] : raw_delta;
		rem_after  = rem_before - {16'd0, delta};
		window_ext = {16'd0, window};
	end

	always_comb begin
		nxt = cur;
		wr  = 1'b0;
		res = '0;
		res.status = ST_OK;
		if (!in_range) begin
			res.status = ST_PARAM;
		end else begin
			unique case (op)
				OP_START: begin
					if (target_pulses == 32'd0) begin
						res.status = ST_PARAM;
					end else if (cur.active) begin
						res.status = ST_BUSY;
					end else begin
						wr               = 1'b1;
						nxt.last_count   = '0;
						nxt.pulses_done  = '0;
						nxt.pulse_target = target_pulses;
						nxt.active       = 1'b1;
						nxt.stop_armed   = 1'b0;
						res.stop_compare = NOT_ARMED_COMPARE;
						if (target_pulses <= window_ext) begin
							res.stop_compare = target_pulses[15:0];
							res.arm_stop     = 1'b1;
							nxt.stop_armed   = 1'b1;
						end
						res.counter_clear = 1'b1;
					end
				end
				OP_POLL: begin
					if (!cur.active) begin
						res.gen_stopped = !pwm_enabled;
					end else begin
						wr               = 1'b1;
						nxt.last_count   = counter_sample;
						nxt.pulses_done  = cur.pulses_done + {16'd0, delta};
						res.pulse_delta  = delta;
						if (!cur.stop_armed && (rem_after != 32'd0) && (rem_after <= window_ext))
						begin
							res.stop_compare = counter_sample + rem_after[15:0];
							res.arm_stop     = 1'b1;
							nxt.stop_armed   = 1'b1;
						end
						if (!pwm_enabled || (rem_after == 32'd0)) begin
							if (rem_after == 32'd0) begin
								nxt.pulses_done = cur.pulse_target;
							end
							res.halt_timers = 1'b1;
							res.gen_stopped = 1'b1;
							nxt.active      = 1'b0;
							nxt.stop_armed  = 1'b0;
						end
					end
				end
				OP_STOP: begin
					wr = 1'b1;
					if (cur.active) begin
						nxt.last_count   = counter_sample;
						nxt.pulses_done  = cur.pulses_done + {16'd0, delta};
						res.pulse_delta  = delta;
					end
					res.halt_timers = 1'b1;
					res.gen_stopped = 1'b1;
					nxt.active      = 1'b0;
					nxt.stop_armed  = 1'b0;
				end
				default: begin
					res.status = ST_PARAM;
				end
			endcase
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse target count tracker testbench
// Drives start, poll and stop requests through the command channel and checks
// every result against a cycle-free model of the per-channel tracking state.
// A directed opening covers the edge cases, then runs of start/poll/stop
// sequences with random content and some noise follow under several arm
// window settings, with random idling on both sides of the block.
// ----------------------------------------------------------------------------
module testbench;
	import ptct_pkg::*;

	localparam int unsigned NUM_CHANNELS = CHANNELS_DEF;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned ITEMS_PER_PHASE = 222;
	localparam int unsigned REPORT_LIMIT = 10;

	class pulse_scoreboard;
		logic [15:0] arm_window;
		entry_t chans[CHANNELS_MAX];
		result_t expected_q[$];
		int unsigned num_channels;
		int unsigned error_count;

		function new(int unsigned channels);
			num_channels = channels;
			arm_window = WINDOW_RESET;
			error_count = 0;
			foreach (chans[i]) chans[i] = '0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function logic [31:0] pulses_left(int unsigned ch);
			if (chans[ch].pulses_done >= chans[ch].pulse_target) return 32'd0;
			return chans[ch].pulse_target - chans[ch].pulses_done;
		endfunction

		function logic [15:0] count_pulses(int unsigned ch, logic [15:0] sample);
			logic [15:0] step;
			logic [31:0] counted;
			logic [31:0] remaining;
			step = sample - chans[ch].last_count;
			chans[ch].last_count = sample;
			remaining = pulses_left(ch);
			counted = {16'd0, step};
			if (counted > remaining) counted = remaining;
			chans[ch].pulses_done = chans[ch].pulses_done + counted;
			return counted[15:0];
		endfunction

		function void note_command(logic [1:0] op, logic [2:0] ch, logic [31:0] goal,
			logic [15:0] sample, logic enabled);
			result_t r;
			logic [31:0] remaining;
			r = '0;
			r.status = ST_OK;
			if (ch >= num_channels || op == OP_UNKNOWN) begin
				r.status = ST_PARAM;
			end else if (op == OP_START) begin
				if (goal == 32'd0) begin
					r.status = ST_PARAM;
				end else if (chans[ch].active) begin
					r.status = ST_BUSY;
				end else begin
					chans[ch] = '0;
					chans[ch].pulse_target = goal;
					chans[ch].active = 1'b1;
					if (goal <= {16'd0, arm_window}) begin
						r.stop_compare = goal[15:0];
						r.arm_stop = 1'b1;
						chans[ch].stop_armed = 1'b1;
					end else begin
						r.stop_compare = NOT_ARMED_COMPARE;
					end
					r.counter_clear = 1'b1;
				end
			end else if (op == OP_POLL) begin
				if (!chans[ch].active) begin
					r.gen_stopped = !enabled;
				end else begin
					r.pulse_delta = count_pulses(ch, sample);
					remaining = pulses_left(ch);
					if (!chans[ch].stop_armed && remaining != 0
						&& remaining <= {16'd0, arm_window}) begin
						r.stop_compare = sample + remaining[15:0];
						r.arm_stop = 1'b1;
						chans[ch].stop_armed = 1'b1;
					end
					if (!enabled || remaining == 0) begin
						if (remaining == 0) chans[ch].pulses_done = chans[ch].pulse_target;
						r.halt_timers = 1'b1;
						r.gen_stopped = 1'b1;
						chans[ch].active = 1'b0;
						chans[ch].stop_armed = 1'b0;
					end
				end
			end else begin
				if (chans[ch].active) r.pulse_delta = count_pulses(ch, sample);
				r.halt_timers = 1'b1;
				r.gen_stopped = 1'b1;
				chans[ch].active = 1'b0;
				chans[ch].stop_armed = 1'b0;
			end
			expected_q.push_back(r);
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%s: expected %0d, got %0d", field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("result arrived with no request outstanding");
				return;
			end
			want = expected_q.pop_front();
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("pulse_delta", 32'(want.pulse_delta), 32'(got.pulse_delta));
			check_field("gen_stopped", 32'(want.gen_stopped), 32'(got.gen_stopped));
			check_field("arm_stop", 32'(want.arm_stop), 32'(got.arm_stop));
			check_field("stop_compare", 32'(want.stop_compare), 32'(got.stop_compare));
			check_field("counter_clear", 32'(want.counter_clear), 32'(got.counter_clear));
			check_field("halt_timers", 32'(want.halt_timers), 32'(got.halt_timers));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic steady;
	logic [15:0] window_now;
	int unsigned items_sent;
	int unsigned cycle_count = 0;
	result_t seen_result;
	pulse_scoreboard sb;

	ptct_cmd_if cmd_ch ();
	ptct_rsp_if rsp_ch ();
	ptct_cfg_if cfg_ch ();

	pulse_target_count_tracker_unit #(
		.CHANNELS(NUM_CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= arst_n && (steady || $urandom_range(0, 99) >= 17);
		end
	end

	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen_result.status = status_t'(rsp_ch.status);
			seen_result.pulse_delta = rsp_ch.pulse_delta;
			seen_result.gen_stopped = rsp_ch.gen_stopped;
			seen_result.arm_stop = rsp_ch.arm_stop;
			seen_result.stop_compare = rsp_ch.stop_compare;
			seen_result.counter_clear = rsp_ch.counter_clear;
			seen_result.halt_timers = rsp_ch.halt_timers;
			sb.check_result(seen_result);
		end
	end

	task automatic send_cmd(logic [1:0] op, logic [2:0] ch, logic [31:0] goal,
		logic [15:0] sample, logic enabled);
		int unsigned gap;
		logic accepted;
		if (!steady && $urandom_range(0, 99) < 14) begin
			gap = $urandom_range(1, 2);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.channel <= ch;
		cmd_ch.target_pulses <= goal;
		cmd_ch.counter_sample <= sample;
		cmd_ch.pwm_enabled <= enabled;
		accepted = 1'b0;
		while (!accepted) begin
			@(negedge clk);
			if (cmd_ch.ready) begin
				accepted = 1'b1;
				sb.note_command(op, ch, goal, sample, enabled);
			end
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic wait_for_results();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_window(logic [15:0] value);
		logic accepted;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		accepted = 1'b0;
		while (!accepted) begin
			@(negedge clk);
			if (cfg_ch.ready) begin
				accepted = 1'b1;
				sb.arm_window = value;
				window_now = value;
			end
			@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_pulse_sequence();
		logic [31:0] goal;
		logic [15:0] count;
		logic [15:0] max_step;
		int goal_guess;
		int unsigned polls;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			goal = $urandom_range(1, 3000);
		end else if (pick < 65) begin
			goal = $urandom_range(1, 70000);
		end else if (pick < 80) begin
			goal = $urandom();
		end else begin
			goal_guess = int'(window_now) + int'($urandom_range(0, 4)) - 2;
			if (goal_guess < 1) goal_guess = 1;
			goal = goal_guess;
		end
		max_step = (goal < 3000) ? goal[15:0] / 2 + 1 : 16'd1500;
		send_cmd(OP_START, 3'd0, goal, 16'($urandom_range(0, 65535)), 1'b1);
		count = 16'd0;
		polls = $urandom_range(1, 8);
		repeat (polls) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) count += 16'($urandom_range(0, 65535));
			else count += 16'($urandom_range(0, max_step));
			if (pick >= 95)
				send_cmd(OP_START, 3'd0, $urandom(), count, 1'b1);
			else if (pick >= 92)
				send_cmd(OP_POLL, 3'($urandom_range(0, 7)), $urandom(), count, 1'b1);
			else
				send_cmd(OP_POLL, 3'd0, $urandom(), count, $urandom_range(0, 99) >= 8);
		end
		if ($urandom_range(0, 99) < 60) begin
			count += 16'($urandom_range(0, 800));
			send_cmd(OP_STOP, 3'd0, $urandom(), count, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(logic [15:0] window, logic quiet);
		int unsigned stop_at;
		wait_for_results();
		write_window(window);
		steady = quiet;
		stop_at = items_sent + ITEMS_PER_PHASE;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 12)
				send_cmd(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom(),
					16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			else
				run_pulse_sequence();
		end
		steady = 1'b0;
	endtask

	initial begin
		sb = new(NUM_CHANNELS);
		steady = 1'b0;
		window_now = WINDOW_RESET;
		items_sent = 0;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.op <= OP_START;
		cmd_ch.channel <= 3'd0;
		cmd_ch.target_pulses <= 32'd0;
		cmd_ch.counter_sample <= 16'd0;
		cmd_ch.pwm_enabled <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd0, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd0, 1'b0);
		send_cmd(OP_STOP, 3'd0, 32'd0, 16'h1234, 1'b1);
		send_cmd(OP_START, 3'd0, 32'd0, 16'd0, 1'b1);
		send_cmd(OP_START, 3'd7, 32'd100, 16'd0, 1'b1);
		send_cmd(OP_UNKNOWN, 3'd0, 32'd100, 16'd0, 1'b1);
		send_cmd(OP_START, 3'd0, 32'd1024, 16'd0, 1'b1);
		send_cmd(OP_START, 3'd0, 32'd50, 16'd0, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd1000, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd1100, 1'b1);
		send_cmd(OP_START, 3'd0, 32'hFFFF_FFFF, 16'd0, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'hFFFF, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd0, 1'b1);
		send_cmd(OP_POLL, 3'd7, 32'd0, 16'd0, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd100, 1'b0);
		send_cmd(OP_START, 3'd0, 32'd2000, 16'd0, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd1500, 1'b1);
		send_cmd(OP_STOP, 3'd0, 32'd0, 16'd1700, 1'b1);
		send_cmd(OP_START, 3'd0, 32'd3000, 16'd0, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd2500, 1'b0);
		send_cmd(OP_START, 3'd0, 32'd1025, 16'd0, 1'b1);
		send_cmd(OP_POLL, 3'd0, 32'd0, 16'd1, 1'b1);
		send_cmd(OP_STOP, 3'd0, 32'd0, 16'd5000, 1'b1);
		send_cmd(OP_STOP, 3'd0, 32'd0, 16'd0, 1'b1);

		run_phase(16'hFFFF, 1'b0);
		run_phase(16'd1, 1'b0);
		run_phase(16'd0, 1'b1);
		run_phase(16'd300, 1'b0);
		run_phase(16'($urandom_range(2, 65534)), 1'b0);
		run_phase(WINDOW_RESET, 1'b0);

		wait_for_results();
		repeat (10) @(posedge clk);
		sb.error_count += sb.pending();
		if (sb.error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
